// ===== hdl/mam_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix add and multiply unit package
// Shared types, codes and constants for the matrix sum and product block.
// ----------------------------------------------------------------------------
package mam_pkg;

    localparam int          MAX_DIM_DEF = 4;
    localparam int          DIM_W       = 3;
    localparam int          ELEM_W      = 16;
    localparam int          PROD_W      = 2 * ELEM_W;
    localparam int          VALUE_W     = 40;
    localparam int          CFG_IDX_W   = 2;
    localparam logic [DIM_W-1:0] RESET_DIM = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    typedef enum logic [1:0] {
        KIND_SUM   = 2'd0,
        KIND_PROD  = 2'd1,
        KIND_NOTSQ = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_NOTSQ,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_sum;
        logic load_notsq;
        logic prod_start;
        logic issue;
        logic load_prod;
        logic next_elem;
    } cmd_t;

    typedef struct packed {
        logic load_end;
        logic square;
        logic k_last;
        logic pipe_busy;
        logic out_free;
        logic prod_last;
    } status_t;

endpackage

// ===== hdl/mam_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mam_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix add and multiply controller
// Sequences loading, the not-square notice and the product element loop.
// ----------------------------------------------------------------------------
module mam_ctrl
    import mam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free)
                begin
                    cmd.load_sum = 1'b1;
                    if (status.load_end)
                    begin
                        if (status.square)
                        begin
                            cmd.prod_start = 1'b1;
                            state_next     = ST_ISSUE;
                        end
                        else
                        begin
                            state_next = ST_NOTSQ;
                        end
                    end
                end
            end
            ST_NOTSQ:
            begin
                if (status.out_free)
                begin
                    cmd.load_notsq = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (status.k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_prod = 1'b1;
                    cmd.next_elem = 1'b1;
                    state_next    = status.prod_last ? ST_LOAD : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/mam_datapath.sv =====
// ----------------------------------------------------------------------------
// Matrix add and multiply datapath
// Configuration, element stores, multiply-accumulate pipeline and output register.
// ----------------------------------------------------------------------------
module mam_datapath
    import mam_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [ELEM_W-1:0]    a_elem,
    input  logic [ELEM_W-1:0]    b_elem,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output kind_t                out_kind,
    output logic [DIM_W-1:0]     out_row,
    output logic [DIM_W-1:0]     out_col,
    output logic [VALUE_W-1:0]   out_value,
    output logic                 out_last,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] nr, nc;

    logic [AW-1:0]    pos_reg;
    logic [DIM_W-1:0] r_reg, c_reg;

    logic [DIM_W-1:0] i_reg, j_reg, k_reg;
    logic [AW-1:0]    row_base_reg, kb_reg;
    logic [AW-1:0]    a_raddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;

    logic                      rd_v_reg, rd_first_reg;
    logic                      mul_v_reg, mul_first_reg;
    logic signed [PROD_W-1:0]  mul_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic signed [VALUE_W-1:0] acc_next;
    logic signed [VALUE_W-1:0] sum_value;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [DIM_W-1:0]     out_row_reg, out_col_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_last_reg;
    logic                 out_free;

    assign cfg_ready = 1'b1;

    // Zero acts as one and anything above the maximum saturates.
    always_comb
    begin
        if (rows_reg == '0)
            nr = DIM_W'(1);
        else if (int'(rows_reg) > MAX_DIM)
            nr = DIM_W'(MAX_DIM);
        else
            nr = rows_reg;
        if (cols_reg == '0)
            nc = DIM_W'(1);
        else if (int'(cols_reg) > MAX_DIM)
            nc = DIM_W'(MAX_DIM);
        else
            nc = cols_reg;
    end

    assign out_free = !out_valid_reg || m_tready;

    assign status.load_end  = (r_reg == nr - DIM_W'(1)) && (c_reg == nc - DIM_W'(1));
    assign status.square    = (nr == nc);
    assign status.k_last    = (k_reg == nc - DIM_W'(1));
    assign status.pipe_busy = rd_v_reg || mul_v_reg;
    assign status.out_free  = out_free;
    assign status.prod_last = (i_reg == nc - DIM_W'(1)) && (j_reg == nc - DIM_W'(1));

    // Configuration and load position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RESET_DIM;
            cols_reg <= RESET_DIM;
            pos_reg  <= '0;
            r_reg    <= '0;
            c_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS:
                begin
                    rows_reg <= cfg_data;
                    pos_reg  <= '0;
                    r_reg    <= '0;
                    c_reg    <= '0;
                end
                REG_COLS:
                begin
                    cols_reg <= cfg_data;
                    pos_reg  <= '0;
                    r_reg    <= '0;
                    c_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.load_sum)
        begin
            if (status.load_end)
            begin
                pos_reg <= '0;
                r_reg   <= '0;
                c_reg   <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + AW'(1);
                if (c_reg == nc - DIM_W'(1))
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + DIM_W'(1);
                end
                else
                begin
                    c_reg <= c_reg + DIM_W'(1);
                end
            end
        end
    end

    // Product element counters: i and j walk the result, k the inner sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            kb_reg       <= '0;
        end
        else if (cmd.prod_start)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            kb_reg       <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                if (status.k_last)
                begin
                    k_reg  <= '0;
                    kb_reg <= '0;
                end
                else
                begin
                    k_reg  <= k_reg + DIM_W'(1);
                    kb_reg <= kb_reg + AW'(nc);
                end
            end
            if (cmd.next_elem)
            begin
                if (j_reg == nc - DIM_W'(1))
                begin
                    j_reg        <= '0;
                    i_reg        <= i_reg + DIM_W'(1);
                    row_base_reg <= row_base_reg + AW'(nc);
                end
                else
                begin
                    j_reg <= j_reg + DIM_W'(1);
                end
            end
        end
    end

    assign a_raddr = row_base_reg + AW'(k_reg);
    assign b_raddr = kb_reg + AW'(j_reg);

    mam_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_a_store (
        .clk   (clk),
        .we    (cmd.load_sum),
        .waddr (pos_reg),
        .wdata (a_elem),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mam_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_b_store (
        .clk   (clk),
        .we    (cmd.load_sum),
        .waddr (pos_reg),
        .wdata (b_elem),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Read, multiply and accumulate stages; the first flag restarts the sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    assign acc_next = mul_first_reg ? VALUE_W'(mul_reg) : acc_reg + VALUE_W'(mul_reg);

    always_ff @(posedge clk)
    begin
        rd_first_reg  <= (k_reg == '0);
        mul_first_reg <= rd_first_reg;
        mul_reg       <= $signed(a_rdata) * $signed(b_rdata);
        if (mul_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum_value = VALUE_W'($signed(a_elem)) + VALUE_W'($signed(b_elem));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_sum || cmd.load_notsq || cmd.load_prod)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sum)
        begin
            out_kind_reg  <= KIND_SUM;
            out_row_reg   <= r_reg;
            out_col_reg   <= c_reg;
            out_value_reg <= sum_value;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.load_notsq)
        begin
            out_kind_reg  <= KIND_NOTSQ;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.load_prod)
        begin
            out_kind_reg  <= KIND_PROD;
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= status.prod_last;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_sum || cmd.load_notsq || cmd.load_prod) |-> out_free)
        else $error("result register overwritten");

    // A product element is only emitted once the accumulate pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_prod |-> !(rd_v_reg || mul_v_reg))
        else $error("product emitted before accumulation finished");

    // The product only starts for square matrices.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prod_start |-> (nr == nc) && cmd.load_sum)
        else $error("product started for non-square matrices");

endmodule

// ===== hdl/matrix_add_and_multiply_unit.sv =====
// A sum element is registered and offered in the cycle after its pair is accepted.
// Throughput: one pair per cycle while loading, while the output is taken.
// Product: each of the n*n elements issues its n terms through the single
// multiply-accumulate unit (read, multiply and accumulate stages), which drains before the next element.
// The not-square notice is loaded from the ST_NOTSQ state after the last sum, once the output is free.
// Reset: control clears and rows and cols return to 4; the stores keep their contents.
// ----------------------------------------------------------------------------
// Matrix add and multiply unit
// Streams element pairs, returns A+B, then A*B for square matrices or a not-square notice.
// ----------------------------------------------------------------------------
module matrix_add_and_multiply_unit
    import mam_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // a_elem[15:0], b_elem[31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // row[2:0], col[5:3], value[45:6], zero[47:46]
    output logic [1:0]           m_tuser,   // kind[1:0]
    output logic                 m_tlast
);

    cmd_t               cmd;
    status_t            status;
    kind_t              out_kind;
    logic [DIM_W-1:0]   out_row, out_col;
    logic [VALUE_W-1:0] out_value;

    mam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mam_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .a_elem    (s_tdata[15:0]),
        .b_elem    (s_tdata[31:16]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_kind  (out_kind),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_tdata = {2'b00, out_value, out_col, out_row};
    assign m_tuser = 2'(out_kind);

endmodule
